@@ design/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, ignored while reset is high
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// clocked assertion that is also checked during reset
`define ASSERT_CLK_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

@@ design/pet_pkg.sv @@
// shared types, constants and helpers of the presence tracker
`timescale 1ns / 1ps

package pet_pkg;

  localparam int CAPACITY = 16;
  localparam int ID_BITS  = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    OP_CONTACT = 2'd0,
    OP_REMOVE  = 2'd1,
    OP_SWEEP   = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    EV_ENTER = 2'd0,
    EV_EXIT  = 2'd1,
    EV_FULL  = 2'd2
  } event_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic contact;
    logic remove;
    logic sweep_init;
    logic sweep_step;
    logic sweep_finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] op;
    logic       slot_free;
    logic       sweep_end;
    logic       cur_unmarked;
  } status_t;

  // port identifier to internal identifier width
  function automatic logic [ID_BITS-1:0] to_id(input logic [15:0] x);
    logic [63:0] wide;
    wide = {48'b0, x};
    return wide[ID_BITS-1:0];
  endfunction

  // internal identifier back to port width
  function automatic logic [15:0] from_id(input logic [ID_BITS-1:0] x);
    logic [63:0] wide;
    wide = 64'(x);
    return wide[15:0];
  endfunction

endpackage

@@ design/pet_ctrl.sv @@
// control state machine of the presence tracker
`timescale 1ns / 1ps

module pet_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  pet_pkg::status_t sts,
  output pet_pkg::cmd_t    cmd
);
  import pet_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_EXEC  = 3'b010,
    S_SWEEP = 3'b100
  } state_t;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        case (sts.op)
          OP_CONTACT: begin
            if (sts.slot_free) begin
              cmd.contact = 1'b1;
              state_next  = S_IDLE;
            end
          end
          OP_REMOVE: begin
            cmd.remove = 1'b1;
            state_next = S_IDLE;
          end
          OP_SWEEP: begin
            cmd.sweep_init = 1'b1;
            state_next     = S_SWEEP;
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_SWEEP: begin
        if (sts.sweep_end) begin
          cmd.sweep_finish = 1'b1;
          state_next       = S_IDLE;
        end else if (!sts.cur_unmarked || sts.slot_free) begin
          cmd.sweep_step = 1'b1;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ design/pet_datapath.sv @@
// table, compare logic, sweep pointers and output register
`timescale 1ns / 1ps

module pet_datapath (
  input  logic             clk,
  input  logic             rst,
  input  pet_pkg::cmd_t    cmd,
  output pet_pkg::status_t sts,
  input  logic [1:0]       op,
  input  logic [15:0]      ident,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       event_res,
  output logic [15:0]      ident_out,
  output logic             last
);
  import pet_pkg::*;

  logic [ID_BITS-1:0]  ids [CAPACITY];
  logic [CAPACITY-1:0] marks;
  logic [CNT_W-1:0]    count;
  logic [1:0]          op_q;
  logic [ID_BITS-1:0]  id_q;
  logic [CNT_W-1:0]    rd;
  logic [CNT_W-1:0]    wr;

  logic [CAPACITY-1:0] hit;
  logic [CAPACITY-1:0] at_or_after;
  logic [CAPACITY-1:0] later_unm;
  logic                any_hit;
  logic                full;
  logic [IDX_W-1:0]    rd_i;
  logic [IDX_W-1:0]    wr_i;
  logic [IDX_W-1:0]    cnt_i;
  logic [ID_BITS-1:0]  cur_id;
  logic                cur_mark;
  logic                slot_free;

  // parallel compare against all valid entries
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      hit[i]       = (CNT_W'(i) < count) && (ids[i] == id_q);
      later_unm[i] = (CNT_W'(i) < count) && !marks[i] && (CNT_W'(i) > rd);
      at_or_after[i] = 1'b0;
      for (int j = 0; j < CAPACITY; j++) begin
        if (j <= i) at_or_after[i] = at_or_after[i] | hit[j];
      end
    end
  end

  assign any_hit   = |hit;
  assign full      = (count == CNT_W'(CAPACITY));
  assign rd_i      = rd[IDX_W-1:0];
  assign wr_i      = wr[IDX_W-1:0];
  assign cnt_i     = count[IDX_W-1:0];
  assign cur_id    = ids[rd_i];
  assign cur_mark  = marks[rd_i];
  assign slot_free = !out_valid || !out_stall;

  assign sts.op           = op_q;
  assign sts.slot_free    = slot_free;
  assign sts.sweep_end    = (rd == count);
  assign sts.cur_unmarked = !cur_mark;

  // table and pointer updates
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      marks <= '0;
    end else begin
      if (cmd.contact) begin
        if (any_hit) begin
          marks <= marks | hit;
        end else if (!full) begin
          ids[cnt_i]   <= id_q;
          marks[cnt_i] <= 1'b1;
          count        <= count + CNT_W'(1);
        end
      end
      if (cmd.remove && any_hit) begin
        for (int i = 0; i < CAPACITY - 1; i++) begin
          if (at_or_after[i]) begin
            ids[i]   <= ids[i+1];
            marks[i] <= marks[i+1];
          end
        end
        count <= count - CNT_W'(1);
      end
      // kept entries slide down to the write pointer with their mark cleared
      if (cmd.sweep_step && cur_mark) begin
        ids[wr_i]   <= cur_id;
        marks[wr_i] <= 1'b0;
      end
      if (cmd.sweep_finish) begin
        count <= wr;
      end
    end
  end

  // input capture and sweep pointers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q <= op;
      id_q <= to_id(ident);
    end
    if (cmd.sweep_init) begin
      rd <= '0;
      wr <= '0;
    end else if (cmd.sweep_step) begin
      rd <= rd + CNT_W'(1);
      if (cur_mark) wr <= wr + CNT_W'(1);
    end
  end

  // output beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (cmd.contact && !any_hit) begin
        out_valid <= 1'b1;
        event_res <= full ? EV_FULL : EV_ENTER;
        ident_out <= from_id(id_q);
        last      <= 1'b1;
      end else if (cmd.sweep_step && !cur_mark) begin
        out_valid <= 1'b1;
        event_res <= EV_EXIT;
        ident_out <= from_id(cur_id);
        last      <= !(|later_unm);
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ design/presence_enter_exit_tracker_top.sv @@
// Presence tracker: ordered table of present identifiers with mark-and-sweep
// enter and exit detection.
// Input channel (in_valid/in_stall) carries op and ident: op contact sets the
// mark of a known identifier or appends a new one with an enter event (a full
// event if the table is full), op removal deletes an entry and closes the gap,
// op sweep emits an exit for every unmarked entry in table order, compacts
// the table and clears all marks.
// Output channel (out_valid/out_stall) carries event_res, ident_out and last;
// last marks the final beat caused by one input beat.
// Timing: an input beat is taken in the idle state and executed in the exec
// state, where a contact waits for a free output slot. A sweep then steps one
// table entry per cycle through the sweep read and write pointers, holding
// while an unmarked entry waits for the output slot. The lookup is a
// combinational compare across all entries. A contact result is registered
// after the exec state; the exits of a sweep follow the pointer setup.
// A stalled receiver holds the output register; a pending result then holds
// the controller, and in_stall stays high until the item is done.
// Reset (rst, synchronous) empties the table and drops any pending result.
`timescale 1ns / 1ps

module presence_enter_exit_tracker_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic [15:0] ident,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  event_res,
  output logic [15:0] ident_out,
  output logic        last
);
  import pet_pkg::*;

  cmd_t    cmd;
  status_t sts;

  // controller
  pet_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath
  pet_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .op        (op),
    .ident     (ident),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .event_res (event_res),
    .ident_out (ident_out),
    .last      (last)
  );

endmodule

@@ design/pet_checker.sv @@
// port-level checks of the presence tracker, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pet_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  event_res,
  input logic [15:0] ident_out,
  input logic        last
);
  import pet_pkg::*;

  logic [18:0] out_beat;
  assign out_beat = {event_res, ident_out, last};

  // a stalled result beat holds its payload
  `ASSERT_CLK(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(out_beat))

  // after reset the block is idle with no pending result
  `ASSERT_CLK_ALWAYS(a_reset_idle, clk, $past(rst) && !rst |-> !in_stall && !out_valid)

  // an accepted beat is executed before the next one is taken
  `ASSERT_CLK(a_busy_after_accept, clk, rst, in_valid && !in_stall |=> in_stall)

  // enter and full events are single-beat results
  `ASSERT_CLK(a_single_last, clk, rst, out_valid && event_res != EV_EXIT |-> last && (event_res == EV_ENTER || event_res == EV_FULL))

endmodule

bind presence_enter_exit_tracker_top pet_checker u_pet_checker (.*);
